### design/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg: shared types and helpers for the coordinate frame transform
// fixed-point widths, config register map, saturation and coefficient unpack
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

  // coordinate and coefficient formats
  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int CFRAC   = COEF_W - 2;
  localparam int IN_W    = (COORD_W < 32) ? COORD_W : 32;
  localparam int PORT_W  = 32;

  // datapath widths
  localparam int PFULL_W = COORD_W + COEF_W;
  localparam int PROD_W  = PFULL_W - CFRAC;
  localparam int SUM_W   = PROD_W + 2;

  // config register widths and bus
  localparam int AXIS_W  = 48;
  localparam int ORGXY_W = 64;
  localparam int ORGZ_W  = 32;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int REG_LSB = 3;

  localparam logic [AXIS_W-1:0] AxisOneRst   = AXIS_W'(64'd16384);
  localparam logic [AXIS_W-1:0] AxisTwoRst   = AXIS_W'(64'd16384 << COEF_W);
  localparam logic [AXIS_W-1:0] AxisThreeRst = AXIS_W'(64'd16384 << (2 * COEF_W));

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef enum logic [ADDR_W-REG_LSB-1:0] {
    REG_AXIS_ONE   = 3'd0,
    REG_AXIS_TWO   = 3'd1,
    REG_AXIS_THREE = 3'd2,
    REG_ORIGIN_XY  = 3'd3,
    REG_ORIGIN_Z   = 3'd4
  } reg_idx_e;

  // per-request flags that travel down the pipe
  typedef struct packed {
    logic kind;
    logic trans;
    logic ovf;
  } side_t;

  // lane stage advance controls
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lane_ctl_t;

  typedef struct packed {
    coord_t value;
    logic   ovf;
  } sat_t;

  // clamp a wide signed value to the coordinate range
  function automatic sat_t sat_coord(input logic signed [SUM_W-1:0] v);
    sat_t                   s;
    logic [SUM_W-COORD_W:0] top_bits;
    top_bits = v[SUM_W-1:COORD_W-1];
    s.ovf = !((&top_bits) || !(|top_bits));
    if (s.ovf) begin
      s.value = v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      s.value = v[COORD_W-1:0];
    end
    return s;
  endfunction

  // entry j of a packed axis row, bits past the register read as zero
  function automatic coef_t get_coef(input logic [AXIS_W-1:0] row, input logic [1:0] j);
    logic [3*COEF_W-1:0] ext;
    ext = (3*COEF_W)'(row);
    return ext[j*COEF_W +: COEF_W];
  endfunction

endpackage

`default_nettype wire

### design/coordinate_frame_transform.sv
// ----------------------------------------------------------------------------
// coordinate_frame_transform: rigid 3-D frame transform, rotation plus origin
// throughput: one point per cycle while out_stall_i is low (handshake below)
// stages: input/subtract, lane multiply, lane sum, merge/add (output register)
// reset: async, clears all stage valids, matrix to identity and origin to zero
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_frame_transform (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // register port
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire logic [cft_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [cft_pkg::DATA_W-1:0]        pwdata,
  output logic [cft_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready,
  // request channel
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire                                    kind_i,
  input  wire                                    translate_i,
  input  wire logic signed [cft_pkg::PORT_W-1:0] in_x_i,
  input  wire logic signed [cft_pkg::PORT_W-1:0] in_y_i,
  input  wire logic signed [cft_pkg::PORT_W-1:0] in_z_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [cft_pkg::PORT_W-1:0]      out_x_o,
  output logic signed [cft_pkg::PORT_W-1:0]      out_y_o,
  output logic signed [cft_pkg::PORT_W-1:0]      out_z_o,
  output logic                                   overflow_o
);
  import cft_pkg::*;

  // --------------------------------------------------------------------------
  // config registers, 8-byte spaced, written on the apb access phase
  // --------------------------------------------------------------------------
  logic [AXIS_W-1:0]  axis_one_q;
  logic [AXIS_W-1:0]  axis_two_q;
  logic [AXIS_W-1:0]  axis_three_q;
  logic [ORGXY_W-1:0] origin_xy_q;
  logic [ORGZ_W-1:0]  origin_z_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:REG_LSB]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_one_q   <= AxisOneRst;
      axis_two_q   <= AxisTwoRst;
      axis_three_q <= AxisThreeRst;
      origin_xy_q  <= '0;
      origin_z_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AXIS_ONE:   axis_one_q   <= pwdata[AXIS_W-1:0];
        REG_AXIS_TWO:   axis_two_q   <= pwdata[AXIS_W-1:0];
        REG_AXIS_THREE: axis_three_q <= pwdata[AXIS_W-1:0];
        REG_ORIGIN_XY:  origin_xy_q  <= pwdata[ORGXY_W-1:0];
        REG_ORIGIN_Z:   origin_z_q   <= pwdata[ORGZ_W-1:0];
        default: ;
      endcase
    end
  end

  // readback, unmapped addresses read zero
  always_comb begin
    unique case (reg_idx)
      REG_AXIS_ONE:   prdata = DATA_W'(axis_one_q);
      REG_AXIS_TWO:   prdata = DATA_W'(axis_two_q);
      REG_AXIS_THREE: prdata = DATA_W'(axis_three_q);
      REG_ORIGIN_XY:  prdata = DATA_W'(origin_xy_q);
      REG_ORIGIN_Z:   prdata = DATA_W'(origin_z_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // unpacked frame: origin vector and 3x3 matrix, rows are frame axes
  // config must change only while idle, not enforced; stages read them directly
  // --------------------------------------------------------------------------
  coord_t            org  [3];
  logic [AXIS_W-1:0] rows [3];
  coef_t             mat  [3][3];

  assign org[0]  = COORD_W'(signed'(origin_xy_q[IN_W-1:0]));
  assign org[1]  = COORD_W'(signed'(origin_xy_q[32 +: IN_W]));
  assign org[2]  = COORD_W'(signed'(origin_z_q[IN_W-1:0]));
  assign rows[0] = axis_one_q;
  assign rows[1] = axis_two_q;
  assign rows[2] = axis_three_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] = get_coef(rows[i], 2'(j));
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage takes a new request when empty or when
  // the stage after it moves, so bubbles collapse; the stall path runs
  // combinationally from the result side back to the request side
  // --------------------------------------------------------------------------
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !vd_q || !out_stall_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  assign in_stall_o  = !rdy_a;
  assign out_valid_o = vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage a: input capture and origin subtract for to-local
  // --------------------------------------------------------------------------
  logic signed [PORT_W-1:0] pt_in [3];
  coord_t                   p_a   [3];
  side_t                    side_a;

  assign pt_in[0] = in_x_i;
  assign pt_in[1] = in_y_i;
  assign pt_in[2] = in_z_i;

  cft_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (rdy_a),
    .kind_i  (kind_i),
    .trans_i (translate_i),
    .pt_i    (pt_in),
    .org_i   (org),
    .side_o  (side_a),
    .p_o     (p_a)
  );

  // --------------------------------------------------------------------------
  // stages b and c: three lanes, one per output component
  // to-local uses matrix row i, to-global uses column i (transpose)
  // --------------------------------------------------------------------------
  coef_t      lane_coef [3][3];
  coord_t     lane_sum  [3];
  logic [2:0] lane_ovf;
  lane_ctl_t  lane_ctl;
  side_t      side_b_q;
  side_t      side_c_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lane_coef[i][j] = side_a.kind ? mat[j][i] : mat[i][j];
      end
    end
  end

  assign lane_ctl.mul_en = rdy_b;
  assign lane_ctl.sum_en = rdy_c;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    cft_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .p_i    (p_a),
      .coef_i (lane_coef[g]),
      .sum_o  (lane_sum[g]),
      .ovf_o  (lane_ovf[g])
    );
  end

  // flags follow the data through the lane stages
  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      side_b_q <= side_a;
    end
    if (rdy_c) begin
      side_c_q <= side_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage d: merge lanes, origin add for to-global, output register
  // --------------------------------------------------------------------------
  coord_t res [3];

  cft_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (rdy_d),
    .side_i     (side_c_q),
    .r_i        (lane_sum),
    .lane_ovf_i (lane_ovf),
    .org_i      (org),
    .out_o      (res),
    .ovf_o      (overflow_o)
  );

  // sign-extend or truncate to the port width
  assign out_x_o = PORT_W'(res[0]);
  assign out_y_o = PORT_W'(res[1]);
  assign out_z_o = PORT_W'(res[2]);

endmodule

`default_nettype wire

### design/cft_prep.sv
// ----------------------------------------------------------------------------
// cft_prep: input stage
// sign-extends the point and, for to-local with translate, subtracts origin
// ----------------------------------------------------------------------------
`default_nettype none

module cft_prep (
  input  wire                                   clk_i,
  input  wire                                   en_i,
  input  wire                                   kind_i,
  input  wire                                   trans_i,
  input  wire logic signed [cft_pkg::PORT_W-1:0] pt_i [3],
  input  wire cft_pkg::coord_t                  org_i [3],
  output cft_pkg::side_t                        side_o,
  output cft_pkg::coord_t                       p_o [3]
);
  import cft_pkg::*;

  coord_t p_ext [3];
  sat_t   sub_s [3];
  coord_t p_d   [3];
  coord_t p_q   [3];
  side_t  side_d;
  side_t  side_q;
  logic   sub_on;

  assign sub_on = !kind_i && trans_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_ext[i] = COORD_W'(signed'(pt_i[i][IN_W-1:0]));
      sub_s[i] = sat_coord(SUM_W'(p_ext[i]) - SUM_W'(org_i[i]));
      p_d[i]   = sub_on ? sub_s[i].value : p_ext[i];
    end
    side_d.kind  = kind_i;
    side_d.trans = trans_i;
    side_d.ovf   = sub_on && (sub_s[0].ovf || sub_s[1].ovf || sub_s[2].ovf);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      side_q <= side_d;
    end
  end

  assign p_o    = p_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

### design/cft_lane.sv
// ----------------------------------------------------------------------------
// cft_lane: one output component
// three registered scaled products, then a saturated sum
// ----------------------------------------------------------------------------
`default_nettype none

module cft_lane (
  input  wire                     clk_i,
  input  wire cft_pkg::lane_ctl_t ctl_i,
  input  wire cft_pkg::coord_t    p_i [3],
  input  wire cft_pkg::coef_t     coef_i [3],
  output cft_pkg::coord_t         sum_o,
  output logic                    ovf_o
);
  import cft_pkg::*;

  logic signed [PFULL_W-1:0] full   [3];
  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [SUM_W-1:0]   acc;
  sat_t                      sat_d;
  coord_t                    sum_q;
  logic                      ovf_q;

  // floor(p * c / 2^frac), exact in the full product
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      full[j]   = PFULL_W'(p_i[j]) * PFULL_W'(coef_i[j]);
      prod_d[j] = PROD_W'(full[j] >>> CFRAC);
    end
  end

  assign acc   = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
  assign sat_d = sat_coord(acc);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctl_i.sum_en) begin
      sum_q <= sat_d.value;
      ovf_q <= sat_d.ovf;
    end
  end

  assign sum_o = sum_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

### design/cft_merge.sv
// ----------------------------------------------------------------------------
// cft_merge: output stage
// gathers the lanes, adds origin for to-global, merges overflow flags
// ----------------------------------------------------------------------------
`default_nettype none

module cft_merge (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  wire cft_pkg::side_t  side_i,
  input  wire cft_pkg::coord_t r_i [3],
  input  wire logic [2:0]      lane_ovf_i,
  input  wire cft_pkg::coord_t org_i [3],
  output cft_pkg::coord_t      out_o [3],
  output logic                 ovf_o
);
  import cft_pkg::*;

  sat_t       add_s [3];
  coord_t     res_d [3];
  coord_t     res_q [3];
  logic [2:0] add_ovf;
  logic       add_on;
  logic       ovf_d;
  logic       ovf_q;

  assign add_on = side_i.kind && side_i.trans;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_s[i]   = sat_coord(SUM_W'(r_i[i]) + SUM_W'(org_i[i]));
      res_d[i]   = add_on ? add_s[i].value : r_i[i];
      add_ovf[i] = add_on && add_s[i].ovf;
    end
    ovf_d = side_i.ovf || (|lane_ovf_i) || (|add_ovf);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

### design/cft_checker.sv
// ----------------------------------------------------------------------------
// cft_checker: port-level checks for the coordinate frame transform
// result hold under stall, pipeline latency and backpressure source
// ----------------------------------------------------------------------------
`default_nettype none

module cft_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_stall_o,
  input wire              out_valid_o,
  input wire              out_stall_i,
  input wire logic [31:0] out_x_o,
  input wire logic [31:0] out_y_o,
  input wire logic [31:0] out_z_o,
  input wire              overflow_o
);

  // a stalled result stays offered
  a_out_hold_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o
  ) else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o) && $stable(overflow_o)
  ) else $error("result payload changed while stalled");

  // an accepted request, with out_stall_i low while it moves down the pipe, reaches out_valid_o
  a_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o
  ) else $error("result missing after pipeline latency");

  // requests are only held off when the pipe is full behind a stalled result
  a_stall_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i
  ) else $error("request stalled without output backpressure");

endmodule

bind coordinate_frame_transform cft_checker u_cft_checker (.*);

`default_nettype wire

### tb/tb_coordinate_frame_transform.sv
// ----------------------------------------------------------------------------
// tb_coordinate_frame_transform: self-checking bench for the frame transform
// drives points over the request channel and configures the frame over the
// register port; a scoreboard predicts every point from its own copy of the
// frame registers and compares each returned point field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_coordinate_frame_transform;
  import cft_pkg::*;

  // transform direction codes on kind_i
  localparam logic TO_LOCAL  = 1'b0;
  localparam logic TO_GLOBAL = 1'b1;

  // unit and extreme coefficients in Q2.14 and coordinate extremes
  localparam logic [15:0] COEF_ONE  = 16'h4000;
  localparam logic [15:0] COEF_NEG  = 16'hC000;
  localparam logic [15:0] COEF_MAX  = 16'h7FFF;
  localparam logic [15:0] COEF_MIN  = 16'h8000;
  localparam logic [31:0] CRD_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] CRD_MIN   = 32'h8000_0000;

  localparam int PHASES       = 7;
  localparam int PHASE_POINTS = 186;
  localparam int HOLD_CYCLES  = 150;   // long result-side hold-off
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all

  // --------------------------------------------------------------------------
  // scoreboard: frame register copy, transform predictor, expected points
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        ovf;
    } point_t;

    logic [AXIS_W-1:0]  axis_row [3];
    logic [ORGXY_W-1:0] org_xy;
    logic [ORGZ_W-1:0]  org_z;
    point_t             expected_points [$];
    int                 errors;

    function new();
      axis_row[0] = AxisOneRst;
      axis_row[1] = AxisTwoRst;
      axis_row[2] = AxisThreeRst;
      org_xy      = '0;
      org_z       = '0;
      errors      = 0;
    endfunction

    function void apply_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_AXIS_ONE:   axis_row[0] = val[AXIS_W-1:0];
        REG_AXIS_TWO:   axis_row[1] = val[AXIS_W-1:0];
        REG_AXIS_THREE: axis_row[2] = val[AXIS_W-1:0];
        REG_ORIGIN_XY:  org_xy = val[ORGXY_W-1:0];
        REG_ORIGIN_Z:   org_z = val[ORGZ_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_coord(longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        return CRD_MAX;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        return CRD_MIN;
      end
      return v[31:0];
    endfunction

    // rotate (and translate) one point with the current frame
    function point_t transform_point(logic kind, logic trans, logic [31:0] x, y, z);
      longint mat [3][3];
      longint org [3];
      longint pnt [3];
      longint res [3];
      longint acc;
      longint m;
      bit     ovf;
      point_t o;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mat[i][j] = longint'($signed(axis_row[i][j*COEF_W +: COEF_W]));
      org[0] = longint'($signed(org_xy[31:0]));
      org[1] = longint'($signed(org_xy[63:32]));
      org[2] = longint'($signed(org_z));
      pnt[0] = longint'($signed(x));
      pnt[1] = longint'($signed(y));
      pnt[2] = longint'($signed(z));
      if (kind == TO_LOCAL && trans)
        for (int i = 0; i < 3; i++)
          pnt[i] = longint'($signed(clamp_coord(pnt[i] - org[i], ovf)));
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          m = (kind == TO_GLOBAL) ? mat[j][i] : mat[i][j];
          acc += (pnt[j] * m) >>> CFRAC;   // floor shift
        end
        res[i] = longint'($signed(clamp_coord(acc, ovf)));
      end
      if (kind == TO_GLOBAL && trans)
        for (int i = 0; i < 3; i++)
          res[i] = longint'($signed(clamp_coord(res[i] + org[i], ovf)));
      o.x   = res[0][31:0];
      o.y   = res[1][31:0];
      o.z   = res[2][31:0];
      o.ovf = ovf;
      return o;
    endfunction

    function void note_request(logic kind, logic trans, logic [31:0] x, y, z);
      expected_points.push_back(transform_point(kind, trans, x, y, z));
    endfunction

    function void check_result(logic [31:0] x, y, z, logic ovf);
      point_t e;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t unexpected result x %h y %h z %h overflow %b", $time, x, y, z, ovf);
        return;
      end
      e = expected_points.pop_front();
      if (x !== e.x) begin
        errors++;
        $display("%0t out_x mismatch: expected %h actual %h", $time, e.x, x);
      end
      if (y !== e.y) begin
        errors++;
        $display("%0t out_y mismatch: expected %h actual %h", $time, e.y, y);
      end
      if (z !== e.z) begin
        errors++;
        $display("%0t out_z mismatch: expected %h actual %h", $time, e.z, z);
      end
      if (ovf !== e.ovf) begin
        errors++;
        $display("%0t overflow mismatch: expected %b actual %b", $time, e.ovf, ovf);
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic                translate_i;
  logic [PORT_W-1:0]   in_x_i;
  logic [PORT_W-1:0]   in_y_i;
  logic [PORT_W-1:0]   in_z_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PORT_W-1:0]   out_x_o;
  logic [PORT_W-1:0]   out_y_o;
  logic [PORT_W-1:0]   out_z_o;
  logic                overflow_o;

  // handshake samples taken mid-cycle, used at the following rising edge
  logic                req_fire;
  logic                res_fire;
  logic [31:0]         res_x;
  logic [31:0]         res_y;
  logic [31:0]         res_z;
  logic                res_ovf;

  // shared control from the sequence to the result side
  bit                  calm;       // no idle cycles on either side
  bit                  hold_req;   // ask the result side for a long hold-off

  frame_scoreboard     sb;

  coordinate_frame_transform DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .translate_i (translate_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .overflow_o  (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // inputs only change at rising edges, so the falling edge sees settled
  // values for the transfer that happens at the next rising edge
  always @(negedge clk_i) begin
    req_fire = in_valid_i && !in_stall_o;
    res_fire = out_valid_o && !out_stall_i;
    res_x    = out_x_o;
    res_y    = out_y_o;
    res_z    = out_z_o;
    res_ovf  = overflow_o;
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [AXIS_W-1:0] axis_of(logic [15:0] ax, ay, az);
    return {az, ay, ax};
  endfunction

  // mix of full-range, small, extreme and near-limit coordinates
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 4))
      0, 1: return v;
      2: return {{12{v[19]}}, v[19:0]};
      3: begin
        case (v[1:0])
          2'd0: return CRD_MAX;
          2'd1: return CRD_MIN;
          2'd2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return v[31] ? CRD_MAX - v[7:0] : CRD_MIN + v[7:0];
    endcase
  endfunction

  // one register write: setup cycle, access cycle, then the bus returns to idle
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // register takes the value at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_frame(input logic [AXIS_W-1:0] a1, a2, a3,
                             input logic [63:0] oxy, input logic [31:0] oz);
    write_reg(REG_AXIS_ONE, DATA_W'(a1));
    write_reg(REG_AXIS_TWO, DATA_W'(a2));
    write_reg(REG_AXIS_THREE, DATA_W'(a3));
    write_reg(REG_ORIGIN_XY, oxy);
    write_reg(REG_ORIGIN_Z, DATA_W'(oz));
  endtask

  // offer one point after a random gap, none when calm, hold it until taken
  task automatic send_point(input logic kind, input logic trans,
                            input logic [31:0] x, y, z);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    translate_i <= trans;
    in_x_i      <= x;
    in_y_i      <= y;
    in_z_i      <= z;
    do @(posedge clk_i); while (!req_fire);
    sb.note_request(kind, trans, x, y, z);
  endtask

  task automatic send_random_point();
    send_point(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
               rand_coord(), rand_coord(), rand_coord());
  endtask

  // stop offering, wait for every outstanding point, let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall per returned point, one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (res_fire) begin
        sb.check_result(res_x, res_y, res_z, res_ovf);
        stall_left = calm ? 0 : $urandom_range(0, 11);
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any transfer on either channel counts as progress
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (req_fire || res_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    logic [AXIS_W-1:0] r1, r2, r3;
    logic [63:0]       oxy;
    logic [31:0]       oz;
    logic [15:0]       sgn [3];
    int                perm;

    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    kind_i      = TO_LOCAL;
    translate_i = 1'b0;
    in_x_i      = '0;
    in_y_i      = '0;
    in_z_i      = '0;
    out_stall_i = 1'b0;
    req_fire    = 1'b0;
    res_fire    = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity frame out of reset, origin zero
    send_point(TO_LOCAL, 1'b0, 32'h0, 32'h0, 32'h0);
    send_point(TO_GLOBAL, 1'b1, 32'h0, 32'h0, 32'h0);
    send_point(TO_LOCAL, 1'b1, CRD_MAX, CRD_MAX, CRD_MAX);
    send_point(TO_GLOBAL, 1'b0, CRD_MIN, CRD_MIN, CRD_MIN);
    send_point(TO_LOCAL, 1'b0, 32'hFFFF_FFFF, 32'h1, CRD_MIN);
    settle();

    // quarter turn about z with an extreme origin: differences and sums clip
    write_frame(axis_of(16'h0, COEF_ONE, 16'h0), axis_of(COEF_NEG, 16'h0, 16'h0),
                axis_of(16'h0, 16'h0, COEF_ONE), {CRD_MIN, CRD_MAX}, 32'h1234_5678);
    send_point(TO_LOCAL, 1'b1, CRD_MIN, CRD_MAX, 32'h0);
    send_point(TO_GLOBAL, 1'b1, CRD_MAX, CRD_MAX, CRD_MAX);
    send_point(TO_LOCAL, 1'b1, CRD_MAX, 32'h0, CRD_MIN);
    send_point(TO_GLOBAL, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_point(TO_LOCAL, 1'b0, CRD_MIN, CRD_MIN, CRD_MIN);
    settle();

    // non-orthonormal matrix, largest entries: rotation sums saturate
    write_frame(axis_of(COEF_MAX, COEF_MAX, COEF_MAX), axis_of(COEF_MAX, COEF_MAX, COEF_MAX),
                axis_of(COEF_MAX, COEF_MAX, COEF_MAX), 64'h0, 32'h0);
    send_point(TO_LOCAL, 1'b0, CRD_MAX, CRD_MAX, CRD_MAX);
    send_point(TO_GLOBAL, 1'b0, CRD_MIN, CRD_MIN, CRD_MIN);
    send_point(TO_LOCAL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(TO_GLOBAL, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h1);
    settle();

    // most negative entries
    write_reg(REG_AXIS_ONE, DATA_W'(axis_of(COEF_MIN, COEF_MIN, COEF_MIN)));
    write_reg(REG_AXIS_TWO, DATA_W'(axis_of(COEF_MIN, COEF_MIN, COEF_MIN)));
    write_reg(REG_AXIS_THREE, DATA_W'(axis_of(COEF_MIN, COEF_MIN, COEF_MIN)));
    send_point(TO_LOCAL, 1'b0, CRD_MIN, CRD_MIN, CRD_MIN);
    send_point(TO_GLOBAL, 1'b1, CRD_MAX, 32'h0, 32'h0);
    settle();

    // random part: one frame setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          // quarter turn again, small origin
          r1  = axis_of(16'h0, COEF_ONE, 16'h0);
          r2  = axis_of(COEF_NEG, 16'h0, 16'h0);
          r3  = axis_of(16'h0, 16'h0, COEF_ONE);
          oxy = {{12{1'b0}}, 20'($urandom()), {12{1'b1}}, 20'($urandom())};
          oz  = {{12{1'b0}}, 20'($urandom())};
        end
        1: begin
          r1  = axis_of(COEF_MAX, COEF_MAX, COEF_MAX);
          r2  = axis_of(COEF_MAX, COEF_MIN, COEF_MAX);
          r3  = axis_of(COEF_MIN, COEF_MAX, COEF_MIN);
          oxy = {CRD_MIN, CRD_MAX};
          oz  = CRD_MAX;
        end
        2: begin
          r1  = axis_of(COEF_MIN, COEF_MIN, COEF_MIN);
          r2  = axis_of(COEF_MIN, COEF_MIN, COEF_MIN);
          r3  = axis_of(COEF_MIN, COEF_MIN, COEF_MIN);
          oxy = {CRD_MIN, CRD_MIN};
          oz  = CRD_MIN;
        end
        3: begin
          r1  = '0;
          r2  = '0;
          r3  = '0;
          oxy = '0;
          oz  = '0;
        end
        4: begin
          r1  = AXIS_W'({$urandom(), $urandom()});
          r2  = AXIS_W'({$urandom(), $urandom()});
          r3  = AXIS_W'({$urandom(), $urandom()});
          oxy = {$urandom(), $urandom()};
          oz  = $urandom();
        end
        5: begin
          r1  = AxisOneRst;
          r2  = AxisTwoRst;
          r3  = AxisThreeRst;
          oxy = {$urandom(), $urandom()};
          oz  = $urandom();
        end
        default: begin
          // signed cyclic axis permutation, an orthonormal frame
          for (int k = 0; k < 3; k++) sgn[k] = $urandom_range(0, 1) ? COEF_ONE : COEF_NEG;
          perm = $urandom_range(0, 2);
          r1 = '0;
          r2 = '0;
          r3 = '0;
          r1[(perm % 3)*COEF_W +: COEF_W]       = sgn[0];
          r2[((perm + 1) % 3)*COEF_W +: COEF_W] = sgn[1];
          r3[((perm + 2) % 3)*COEF_W +: COEF_W] = sgn[2];
          oxy = {$urandom(), $urandom()};
          oz  = $urandom();
        end
      endcase
      write_frame(r1, r2, r3, oxy, oz);

      if (ph == 0) begin
        // result side holds off while points keep coming, so the pipe fills
        // and backs up into the request channel; then wait for all of them
        hold_req = 1'b1;
        calm     = 1'b1;
        for (int n = 0; n < 40; n++) send_random_point();
        calm = 1'b0;
        settle();
      end

      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        if (n == PHASE_POINTS / 2) settle();
        send_random_point();
      end
      calm = 1'b0;
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
